[rtl/pplight_pkg.sv]
// ----------------------------------------------------------------------------
// pplight_pkg
// Shared widths, latencies, register indexes and types of the point-light
// Phong shader.
// ----------------------------------------------------------------------------
package pplight_pkg;

    // register map of the configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_TERM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPECULAR_GAIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHININESS     = 3'd6;

    // number of shininess bits taken by the power chain (1..8 with an 8-bit register)
    localparam int EXPONENT_BITS = 8;
    localparam int PW_STAGES     = 2 * EXPONENT_BITS;

    localparam int ONE_Q14 = 16384;
    localparam int ONE_Q15 = 32768;

    // normalizer datapath
    localparam int NORM_W     = 36;   // signed input component
    localparam int MAG_W      = 36;   // magnitude of an input component
    localparam int SHM_W      = 30;   // magnitude after alignment to [2^29, 2^30)
    localparam int SQ_W       = 2 * SHM_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_W     = 31;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int QUO_W      = 15;
    localparam int DIV_STEPS  = QUO_W;
    localparam int DNUM_W     = SHM_W + 14;
    localparam int UV_W       = 16;   // Q2.14 unit vector component
    // six front stages, one per root bit, one per quotient bit, sign stage
    localparam int NORM_LAT   = 6 + ROOT_STEPS + DIV_STEPS + 1;

    typedef logic signed [NORM_W-1:0] nvec_t;
    typedef logic signed [UV_W-1:0]   uvec_t;

endpackage

[rtl/pplight_norm.sv]
// ----------------------------------------------------------------------------
// pplight_norm
// Pipelined vector normalizer: aligns the three magnitudes, takes the floor
// square root of the sum of squares one bit per stage, then divides each
// component by the length one quotient bit per stage. Output is Q2.14.
// ----------------------------------------------------------------------------
module pplight_norm import pplight_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  nvec_t in_vec [3],
    output logic  out_valid,
    output uvec_t out_vec [3]
);

    // stage 1: sign and magnitude, largest magnitude
    logic             s1_valid_reg;
    logic             s1_neg_reg  [3];
    logic [MAG_W-1:0] s1_mag_reg  [3];
    logic [MAG_W-1:0] s1_mx_reg;
    logic             s1_neg_next [3];
    logic [MAG_W-1:0] s1_mag_next [3];
    logic [MAG_W-1:0] s1_mx_next;

    // stage 2: leading one per six-bit group
    logic             s2_valid_reg;
    logic             s2_neg_reg  [3];
    logic [MAG_W-1:0] s2_mag_reg  [3];
    logic [5:0]       s2_nz_reg;
    logic [2:0]       s2_lpos_reg [6];
    logic [5:0]       s2_nz_next;
    logic [2:0]       s2_lpos_next [6];

    // stage 3: shift direction and amount
    logic             s3_valid_reg;
    logic             s3_neg_reg  [3];
    logic [MAG_W-1:0] s3_mag_reg  [3];
    logic             s3_zero_reg;
    logic             s3_right_reg;
    logic [4:0]       s3_amt_reg;
    logic             s3_zero_next;
    logic             s3_right_next;
    logic [4:0]       s3_amt_next;
    logic [5:0]       pos;

    // stage 4: aligned magnitudes
    logic             s4_valid_reg;
    logic             s4_neg_reg  [3];
    logic             s4_zero_reg;
    logic [SHM_W-1:0] s4_m_reg    [3];
    logic [SHM_W-1:0] s4_m_next   [3];
    logic [MAG_W-1:0] shifted;

    // stage 5: squares, stage 6: sum
    logic             s5_valid_reg;
    logic             s5_neg_reg  [3];
    logic             s5_zero_reg;
    logic [SHM_W-1:0] s5_m_reg    [3];
    logic [SQ_W-1:0]  s5_sq_reg   [3];
    logic             s6_valid_reg;
    logic             s6_neg_reg  [3];
    logic             s6_zero_reg;
    logic [SHM_W-1:0] s6_m_reg    [3];
    logic [SUM_W-1:0] s6_sum_reg;

    // square root stages
    logic [ROOT_STEPS-1:0] rt_valid_reg;
    logic [SUM_W-1:0]      rt_rem_reg   [ROOT_STEPS];
    logic [ROOT_W-1:0]     rt_root_reg  [ROOT_STEPS];
    logic [SHM_W-1:0]      rt_m_reg     [ROOT_STEPS][3];
    logic                  rt_neg_reg   [ROOT_STEPS][3];
    logic                  rt_zero_reg  [ROOT_STEPS];
    logic [SUM_W-1:0]      rt_rem_next  [ROOT_STEPS];
    logic [ROOT_W-1:0]     rt_root_next [ROOT_STEPS];
    logic [SHM_W-1:0]      rt_m_next    [ROOT_STEPS][3];
    logic                  rt_neg_next  [ROOT_STEPS][3];
    logic                  rt_zero_next [ROOT_STEPS];
    logic [ROOT_STEPS-1:0] rt_valid_next;
    logic [SUM_W-1:0]      rt_rem_src;
    logic [ROOT_W-1:0]     rt_root_src;
    logic [63:0]           rt_trial;

    // division stages
    logic [DIV_STEPS-1:0] dv_valid_reg;
    logic [DNUM_W-1:0]    dv_rem_reg   [DIV_STEPS][3];
    logic [QUO_W-1:0]     dv_q_reg     [DIV_STEPS][3];
    logic [ROOT_W-1:0]    dv_len_reg   [DIV_STEPS];
    logic                 dv_neg_reg   [DIV_STEPS][3];
    logic                 dv_zero_reg  [DIV_STEPS];
    logic [DNUM_W-1:0]    dv_rem_next  [DIV_STEPS][3];
    logic [QUO_W-1:0]     dv_q_next    [DIV_STEPS][3];
    logic [ROOT_W-1:0]    dv_len_next  [DIV_STEPS];
    logic                 dv_neg_next  [DIV_STEPS][3];
    logic                 dv_zero_next [DIV_STEPS];
    logic [DIV_STEPS-1:0] dv_valid_next;
    logic [DNUM_W-1:0]    dv_rem_src;
    logic [QUO_W-1:0]     dv_q_src;
    logic [47:0]          dv_trial;

    // sign stage
    logic  out_valid_reg;
    uvec_t out_vec_reg  [3];
    uvec_t out_vec_next [3];

    always_comb begin
        s1_mx_next = '0;
        for (int i = 0; i < 3; i++) begin
            s1_neg_next[i] = in_vec[i][NORM_W-1];
            s1_mag_next[i] = s1_neg_next[i] ? MAG_W'(-in_vec[i]) : MAG_W'(in_vec[i]);
            if (s1_mag_next[i] > s1_mx_next) begin
                s1_mx_next = s1_mag_next[i];
            end
        end
    end

    always_comb begin
        for (int g = 0; g < 6; g++) begin
            s2_nz_next[g]   = |s1_mx_reg[6*g +: 6];
            s2_lpos_next[g] = '0;
            for (int b = 0; b < 6; b++) begin
                if (s1_mx_reg[6*g + b]) begin
                    s2_lpos_next[g] = 3'(b);
                end
            end
        end
    end

    always_comb begin
        pos = '0;
        for (int g = 0; g < 6; g++) begin
            if (s2_nz_reg[g]) begin
                pos = 6'(6*g) + 6'(s2_lpos_reg[g]);
            end
        end
        s3_zero_next  = ~|s2_nz_reg;
        s3_right_next = (pos > 6'd29);
        s3_amt_next   = s3_right_next ? 5'(pos - 6'd29) : 5'(6'd29 - pos);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            shifted      = s3_right_reg ? (s3_mag_reg[i] >> s3_amt_reg)
                                        : (s3_mag_reg[i] << s3_amt_reg);
            s4_m_next[i] = shifted[SHM_W-1:0];
        end
    end

    // one root bit per stage: keep rem = x - root^2
    always_comb begin
        rt_rem_src  = '0;
        rt_root_src = '0;
        rt_trial    = '0;
        for (int j = 0; j < ROOT_STEPS; j++) begin
            if (j == 0) begin
                rt_rem_src       = s6_sum_reg;
                rt_root_src      = '0;
                rt_m_next[j]     = s6_m_reg;
                rt_neg_next[j]   = s6_neg_reg;
                rt_zero_next[j]  = s6_zero_reg;
                rt_valid_next[j] = s6_valid_reg;
            end else begin
                rt_rem_src       = rt_rem_reg[j-1];
                rt_root_src      = rt_root_reg[j-1];
                rt_m_next[j]     = rt_m_reg[j-1];
                rt_neg_next[j]   = rt_neg_reg[j-1];
                rt_zero_next[j]  = rt_zero_reg[j-1];
                rt_valid_next[j] = rt_valid_reg[j-1];
            end
            rt_trial = (64'(rt_root_src) << (ROOT_STEPS - j))
                     + (64'd1 << (2 * (ROOT_STEPS - 1 - j)));
            if (64'(rt_rem_src) >= rt_trial) begin
                rt_rem_next[j]  = SUM_W'(64'(rt_rem_src) - rt_trial);
                rt_root_next[j] = rt_root_src | (ROOT_W'(1) << (ROOT_STEPS - 1 - j));
            end else begin
                rt_rem_next[j]  = rt_rem_src;
                rt_root_next[j] = rt_root_src;
            end
        end
    end

    // one quotient bit per stage, restoring
    always_comb begin
        dv_rem_src = '0;
        dv_q_src   = '0;
        dv_trial   = '0;
        for (int j = 0; j < DIV_STEPS; j++) begin
            if (j == 0) begin
                dv_len_next[j]   = rt_root_reg[ROOT_STEPS-1];
                dv_neg_next[j]   = rt_neg_reg[ROOT_STEPS-1];
                dv_zero_next[j]  = rt_zero_reg[ROOT_STEPS-1];
                dv_valid_next[j] = rt_valid_reg[ROOT_STEPS-1];
            end else begin
                dv_len_next[j]   = dv_len_reg[j-1];
                dv_neg_next[j]   = dv_neg_reg[j-1];
                dv_zero_next[j]  = dv_zero_reg[j-1];
                dv_valid_next[j] = dv_valid_reg[j-1];
            end
            dv_trial = 48'(dv_len_next[j]) << (DIV_STEPS - 1 - j);
            for (int i = 0; i < 3; i++) begin
                if (j == 0) begin
                    dv_rem_src = {rt_m_reg[ROOT_STEPS-1][i], 14'd0};
                    dv_q_src   = '0;
                end else begin
                    dv_rem_src = dv_rem_reg[j-1][i];
                    dv_q_src   = dv_q_reg[j-1][i];
                end
                if (48'(dv_rem_src) >= dv_trial) begin
                    dv_rem_next[j][i] = DNUM_W'(48'(dv_rem_src) - dv_trial);
                    dv_q_next[j][i]   = dv_q_src | (QUO_W'(1) << (DIV_STEPS - 1 - j));
                end else begin
                    dv_rem_next[j][i] = dv_rem_src;
                    dv_q_next[j][i]   = dv_q_src;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dv_zero_reg[DIV_STEPS-1]) begin
                out_vec_next[i] = '0;
            end else if (dv_neg_reg[DIV_STEPS-1][i]) begin
                out_vec_next[i] = -UV_W'(dv_q_reg[DIV_STEPS-1][i]);
            end else begin
                out_vec_next[i] = UV_W'(dv_q_reg[DIV_STEPS-1][i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            rt_valid_reg  <= '0;
            dv_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            rt_valid_reg  <= rt_valid_next;
            dv_valid_reg  <= dv_valid_next;
            out_valid_reg <= dv_valid_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_neg_reg   <= s1_neg_next;
            s1_mag_reg   <= s1_mag_next;
            s1_mx_reg    <= s1_mx_next;
            s2_neg_reg   <= s1_neg_reg;
            s2_mag_reg   <= s1_mag_reg;
            s2_nz_reg    <= s2_nz_next;
            s2_lpos_reg  <= s2_lpos_next;
            s3_neg_reg   <= s2_neg_reg;
            s3_mag_reg   <= s2_mag_reg;
            s3_zero_reg  <= s3_zero_next;
            s3_right_reg <= s3_right_next;
            s3_amt_reg   <= s3_amt_next;
            s4_neg_reg   <= s3_neg_reg;
            s4_zero_reg  <= s3_zero_reg;
            s4_m_reg     <= s4_m_next;
            s5_neg_reg   <= s4_neg_reg;
            s5_zero_reg  <= s4_zero_reg;
            s5_m_reg     <= s4_m_reg;
            for (int i = 0; i < 3; i++) begin
                s5_sq_reg[i] <= s4_m_reg[i] * s4_m_reg[i];
            end
            s6_neg_reg   <= s5_neg_reg;
            s6_zero_reg  <= s5_zero_reg;
            s6_m_reg     <= s5_m_reg;
            s6_sum_reg   <= SUM_W'(s5_sq_reg[0]) + SUM_W'(s5_sq_reg[1])
                          + SUM_W'(s5_sq_reg[2]);
            rt_rem_reg   <= rt_rem_next;
            rt_root_reg  <= rt_root_next;
            rt_m_reg     <= rt_m_next;
            rt_neg_reg   <= rt_neg_next;
            rt_zero_reg  <= rt_zero_next;
            dv_rem_reg   <= dv_rem_next;
            dv_q_reg     <= dv_q_next;
            dv_len_reg   <= dv_len_next;
            dv_neg_reg   <= dv_neg_next;
            dv_zero_reg  <= dv_zero_next;
            out_vec_reg  <= out_vec_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vec   = out_vec_reg;

endmodule

[rtl/phong_point_light_intensity.sv]
// Phong shading of one surface point lit by one point light. One request
// (surface point, unit normal, unit view vector) is taken every clock while
// the output does not stall. One intensity comes out per request, in order,
// after 130 register stages, the first loaded at the edge that took it.
// The length is set by the two vector normalizers (53 stages each: alignment,
// a square root one bit per stage and a division one quotient bit per stage)
// and by the power chain (two multiply stages per exponent bit). The whole
// pipeline advances together; it holds only while a finished result waits at
// the output. Light registers are to be written through the configuration
// port only while no request is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
// phong_point_light_intensity
// Top level: light direction, diffuse term, reflection, specular power,
// ambient add and saturation.
// ----------------------------------------------------------------------------
module phong_point_light_intensity import pplight_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    // requests
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_point_x,
    input  logic signed [31:0]   s_point_y,
    input  logic signed [31:0]   s_point_z,
    input  logic signed [15:0]   s_normal_x,
    input  logic signed [15:0]   s_normal_y,
    input  logic signed [15:0]   s_normal_z,
    input  logic signed [15:0]   s_view_x,
    input  logic signed [15:0]   s_view_y,
    input  logic signed [15:0]   s_view_z,
    // results
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [15:0]          m_intensity
);

    logic signed [31:0] light_x_reg, light_y_reg, light_z_reg;
    logic [15:0]        ambient_term_reg, diffuse_gain_reg, specular_gain_reg;
    logic [7:0]         shininess_reg;
    logic [15:0]        shin_ext;
    logic [EXPONENT_BITS-1:0] expo;

    logic adv;

    // stage 0: light minus point
    logic  t0_valid_reg;
    nvec_t t0_d_reg [3];
    uvec_t t0_n_reg [3];
    uvec_t t0_v_reg [3];
    nvec_t t0_d_next [3];
    logic signed [32:0] diff_x, diff_y, diff_z;

    // first normalizer and side delay lines
    logic  l_valid;
    uvec_t l_vec [3];
    uvec_t n_dl_reg  [NORM_LAT][3];
    uvec_t v1_dl_reg [NORM_LAT][3];

    logic               t1_valid_reg;
    logic signed [31:0] t1_prod_reg [3];
    uvec_t              t1_n_reg [3];
    uvec_t              t1_l_reg [3];
    uvec_t              t1_v_reg [3];

    logic               t2_valid_reg;
    logic signed [17:0] t2_nl_reg;
    uvec_t              t2_n_reg [3];
    uvec_t              t2_l_reg [3];
    uvec_t              t2_v_reg [3];
    logic signed [33:0] nl_sum;
    logic signed [33:0] nl_shr;

    logic               t3_valid_reg;
    logic [18:0]        t3_diff_reg;
    nvec_t              t3_r_reg [3];
    uvec_t              t3_v_reg [3];
    logic [18:0]        t3_diff_next;
    nvec_t              t3_r_next [3];
    logic [32:0]        diff_prod;
    logic signed [33:0] nln_prod;

    // second normalizer and side delay lines
    logic        rr_valid;
    uvec_t       rr_vec [3];
    logic [18:0] diff_dl_reg [NORM_LAT];
    uvec_t       v2_dl_reg   [NORM_LAT][3];

    logic               t4_valid_reg;
    logic signed [31:0] t4_prod_reg [3];
    logic [18:0]        t4_diff_reg;

    logic               t5_valid_reg;
    logic [14:0]        t5_rv_reg;
    logic [18:0]        t5_diff_reg;
    logic signed [33:0] rv_sum;
    logic signed [33:0] rv_shr;
    logic [14:0]        t5_rv_next;

    // power chain: square, then multiply by rv when the exponent bit is set
    logic [PW_STAGES-1:0] pw_valid_reg;
    logic [14:0]          pw_p_reg    [PW_STAGES];
    logic [14:0]          pw_rv_reg   [PW_STAGES];
    logic [18:0]          pw_diff_reg [PW_STAGES];
    logic [PW_STAGES-1:0] pw_valid_next;
    logic [14:0]          pw_p_next    [PW_STAGES];
    logic [14:0]          pw_rv_next   [PW_STAGES];
    logic [18:0]          pw_diff_next [PW_STAGES];
    logic [14:0]          pw_p_src;
    logic [29:0]          pw_prod;

    logic        sp_valid_reg;
    logic [15:0] sp_spec_reg;
    logic [18:0] sp_diff_reg;
    logic [30:0] spec_prod;

    logic        m_valid_reg;
    logic [15:0] m_intensity_reg;
    logic [20:0] total;
    logic [15:0] m_intensity_next;

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_x_reg       <= 32'sd655360;
            light_y_reg       <= 32'sd655360;
            light_z_reg       <= 32'sd1310720;
            ambient_term_reg  <= 16'd13107;
            diffuse_gain_reg  <= 16'd16384;
            specular_gain_reg <= 16'd16384;
            shininess_reg     <= 8'd32;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LIGHT_X:       light_x_reg       <= cfg_data;
                REG_LIGHT_Y:       light_y_reg       <= cfg_data;
                REG_LIGHT_Z:       light_z_reg       <= cfg_data;
                REG_AMBIENT_TERM:  ambient_term_reg  <= cfg_data[15:0];
                REG_DIFFUSE_GAIN:  diffuse_gain_reg  <= cfg_data[15:0];
                REG_SPECULAR_GAIN: specular_gain_reg <= cfg_data[15:0];
                REG_SHININESS:     shininess_reg     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign shin_ext = {8'd0, shininess_reg};
    assign expo     = shin_ext[EXPONENT_BITS-1:0];

    always_comb begin
        diff_x = {light_x_reg[31], light_x_reg} - {s_point_x[31], s_point_x};
        diff_y = {light_y_reg[31], light_y_reg} - {s_point_y[31], s_point_y};
        diff_z = {light_z_reg[31], light_z_reg} - {s_point_z[31], s_point_z};
        t0_d_next[0] = {{(NORM_W-33){diff_x[32]}}, diff_x};
        t0_d_next[1] = {{(NORM_W-33){diff_y[32]}}, diff_y};
        t0_d_next[2] = {{(NORM_W-33){diff_z[32]}}, diff_z};
    end

    pplight_norm u_norm_l (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (t0_valid_reg),
        .in_vec    (t0_d_reg),
        .out_valid (l_valid),
        .out_vec   (l_vec)
    );

    always_comb begin
        nl_sum = 34'(t1_prod_reg[0]) + 34'(t1_prod_reg[1]) + 34'(t1_prod_reg[2]);
        nl_shr = nl_sum >>> 14;
    end

    // diffuse and reflection vector 2 (N.L) N - L on Q8.28
    always_comb begin
        diff_prod    = 33'(diffuse_gain_reg) * 33'(t2_nl_reg[16:0]);
        t3_diff_next = (t2_nl_reg > 18'sd0) ? diff_prod[32:14] : '0;
        nln_prod     = '0;
        for (int i = 0; i < 3; i++) begin
            nln_prod     = t2_nl_reg * t2_n_reg[i];
            t3_r_next[i] = ({{(NORM_W-34){nln_prod[33]}}, nln_prod} <<< 1)
                         - ({{(NORM_W-UV_W){t2_l_reg[i][UV_W-1]}}, t2_l_reg[i]} <<< 14);
        end
    end

    pplight_norm u_norm_r (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (t3_valid_reg),
        .in_vec    (t3_r_reg),
        .out_valid (rr_valid),
        .out_vec   (rr_vec)
    );

    // clamp the reflection-view dot to [0, 1.0]
    always_comb begin
        rv_sum = 34'(t4_prod_reg[0]) + 34'(t4_prod_reg[1]) + 34'(t4_prod_reg[2]);
        rv_shr = rv_sum >>> 14;
        if (rv_shr < 34'sd0) begin
            t5_rv_next = '0;
        end else if (rv_shr > 34'(ONE_Q14)) begin
            t5_rv_next = 15'(ONE_Q14);
        end else begin
            t5_rv_next = rv_shr[14:0];
        end
    end

    always_comb begin
        pw_p_src = '0;
        pw_prod  = '0;
        for (int j = 0; j < PW_STAGES; j++) begin
            if (j == 0) begin
                pw_p_src         = 15'(ONE_Q14);
                pw_rv_next[j]    = t5_rv_reg;
                pw_diff_next[j]  = t5_diff_reg;
                pw_valid_next[j] = t5_valid_reg;
            end else begin
                pw_p_src         = pw_p_reg[j-1];
                pw_rv_next[j]    = pw_rv_reg[j-1];
                pw_diff_next[j]  = pw_diff_reg[j-1];
                pw_valid_next[j] = pw_valid_reg[j-1];
            end
            if ((j & 1) == 0) begin
                pw_prod      = pw_p_src * pw_p_src;
                pw_p_next[j] = pw_prod[28:14];
            end else if (expo[EXPONENT_BITS - 1 - (j >> 1)]) begin
                pw_prod      = pw_p_src * pw_rv_next[j];
                pw_p_next[j] = pw_prod[28:14];
            end else begin
                pw_p_next[j] = pw_p_src;
            end
        end
    end

    assign spec_prod = 31'(specular_gain_reg) * 31'(pw_p_reg[PW_STAGES-1]);

    always_comb begin
        total = 21'(ambient_term_reg) + 21'(sp_diff_reg) + 21'(sp_spec_reg);
        if (total > 21'(ONE_Q15)) begin
            m_intensity_next = 16'(ONE_Q15);
        end else begin
            m_intensity_next = total[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t0_valid_reg <= 1'b0;
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            t4_valid_reg <= 1'b0;
            t5_valid_reg <= 1'b0;
            pw_valid_reg <= '0;
            sp_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            t0_valid_reg <= s_valid;
            t1_valid_reg <= l_valid;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= t2_valid_reg;
            t4_valid_reg <= rr_valid;
            t5_valid_reg <= t4_valid_reg;
            pw_valid_reg <= pw_valid_next;
            sp_valid_reg <= pw_valid_reg[PW_STAGES-1];
            m_valid_reg  <= sp_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t0_d_reg    <= t0_d_next;
            t0_n_reg[0] <= s_normal_x;
            t0_n_reg[1] <= s_normal_y;
            t0_n_reg[2] <= s_normal_z;
            t0_v_reg[0] <= s_view_x;
            t0_v_reg[1] <= s_view_y;
            t0_v_reg[2] <= s_view_z;

            n_dl_reg[0]  <= t0_n_reg;
            v1_dl_reg[0] <= t0_v_reg;
            for (int k = 1; k < NORM_LAT; k++) begin
                n_dl_reg[k]  <= n_dl_reg[k-1];
                v1_dl_reg[k] <= v1_dl_reg[k-1];
            end

            for (int i = 0; i < 3; i++) begin
                t1_prod_reg[i] <= n_dl_reg[NORM_LAT-1][i] * l_vec[i];
            end
            t1_n_reg <= n_dl_reg[NORM_LAT-1];
            t1_l_reg <= l_vec;
            t1_v_reg <= v1_dl_reg[NORM_LAT-1];

            t2_nl_reg <= nl_shr[17:0];
            t2_n_reg  <= t1_n_reg;
            t2_l_reg  <= t1_l_reg;
            t2_v_reg  <= t1_v_reg;

            t3_diff_reg <= t3_diff_next;
            t3_r_reg    <= t3_r_next;
            t3_v_reg    <= t2_v_reg;

            diff_dl_reg[0] <= t3_diff_reg;
            v2_dl_reg[0]   <= t3_v_reg;
            for (int k = 1; k < NORM_LAT; k++) begin
                diff_dl_reg[k] <= diff_dl_reg[k-1];
                v2_dl_reg[k]   <= v2_dl_reg[k-1];
            end

            for (int i = 0; i < 3; i++) begin
                t4_prod_reg[i] <= rr_vec[i] * v2_dl_reg[NORM_LAT-1][i];
            end
            t4_diff_reg <= diff_dl_reg[NORM_LAT-1];

            t5_rv_reg   <= t5_rv_next;
            t5_diff_reg <= t4_diff_reg;

            pw_p_reg    <= pw_p_next;
            pw_rv_reg   <= pw_rv_next;
            pw_diff_reg <= pw_diff_next;

            sp_spec_reg <= spec_prod[29:14];
            sp_diff_reg <= pw_diff_reg[PW_STAGES-1];

            m_intensity_reg <= m_intensity_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_intensity = m_intensity_reg;

endmodule

[rtl/pplight_checker.sv]
// ----------------------------------------------------------------------------
// pplight_checker
// Port-level checks of the point-light shader, bound to the top level.
// ----------------------------------------------------------------------------
module pplight_checker import pplight_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [31:0]          cfg_data,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [15:0]          m_intensity
);

    // a held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_intensity))
        else $error("result changed while stalled");

    // the pipeline takes a request exactly when its output is free or drains
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("request side not tied to output stall");

    // sum is saturated at 1.0
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_intensity <= 16'(ONE_Q15))
        else $error("intensity above 1.0");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind phong_point_light_intensity pplight_checker u_pplight_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_intensity (m_intensity)
);

[bench/phong_point_light_intensity_checker.sv]
// ----------------------------------------------------------------------------
// phong_point_light_intensity_checker
// Watches the configuration, request and result channels of the point-light
// shader. It keeps its own copy of the light registers, predicts the
// intensity of every accepted request and compares results in order.
// ----------------------------------------------------------------------------
module phong_point_light_intensity_checker import pplight_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic signed [31:0]   s_point_x,
    input  logic signed [31:0]   s_point_y,
    input  logic signed [31:0]   s_point_z,
    input  logic signed [15:0]   s_normal_x,
    input  logic signed [15:0]   s_normal_y,
    input  logic signed [15:0]   s_normal_z,
    input  logic signed [15:0]   s_view_x,
    input  logic signed [15:0]   s_view_y,
    input  logic signed [15:0]   s_view_z,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [15:0]          m_intensity,
    output int                   mismatches,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint vec3_t [3];

    logic signed [31:0] light_x, light_y, light_z;
    logic [15:0]        ambient_term, diffuse_gain, specular_gain;
    logic [7:0]         shininess;
    logic [15:0]        intensity_q[$];

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Q2.14 unit vector; align magnitudes into [2^29, 2^30) first
    function automatic void unit_vec(input vec3_t a, output vec3_t o);
        longint unsigned m[3];
        longint unsigned mx, sum, len;
        bit ng[3];
        longint q;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            ng[i] = a[i] < 0;
            m[i] = ng[i] ? longint'(-a[i]) : longint'(a[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return;
        end
        while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = longint'((m[i] << 14) / len);
            o[i] = ng[i] ? -q : q;
        end
    endfunction

    function automatic logic [15:0] shade_point(
        input longint px, input longint py, input longint pz,
        input vec3_t n, input vec3_t v);
        vec3_t d, l, r, rr;
        longint nl, rv, dif, spec, total, p;
        logic [EXPONENT_BITS-1:0] e;
        e = shininess[EXPONENT_BITS-1:0];
        d[0] = longint'(light_x) - px;
        d[1] = longint'(light_y) - py;
        d[2] = longint'(light_z) - pz;
        unit_vec(d, l);
        nl = (n[0] * l[0] + n[1] * l[1] + n[2] * l[2]) >>> 14;
        dif = 0;
        if (nl > 0) dif = (longint'(diffuse_gain) * nl) >>> 14;
        for (int i = 0; i < 3; i++) r[i] = 2 * nl * n[i] - l[i] * ONE_Q14;
        unit_vec(r, rr);
        rv = (rr[0] * v[0] + rr[1] * v[1] + rr[2] * v[2]) >>> 14;
        if (rv < 0) rv = 0;
        if (rv > ONE_Q14) rv = ONE_Q14;
        p = ONE_Q14;
        for (int i = EXPONENT_BITS - 1; i >= 0; i--) begin
            p = (p * p) >>> 14;
            if (e[i]) p = (p * rv) >>> 14;
        end
        spec = (longint'(specular_gain) * p) >>> 14;
        total = longint'(ambient_term) + dif + spec;
        if (total > ONE_Q15) total = ONE_Q15;
        return total[15:0];
    endfunction

    assign pending = intensity_q.size();

    always @(posedge aclk) begin
        vec3_t n, v;
        logic [15:0] want;
        if (!aresetn) begin
            light_x       <= 32'sd655360;
            light_y       <= 32'sd655360;
            light_z       <= 32'sd1310720;
            ambient_term  <= 16'd13107;
            diffuse_gain  <= 16'd16384;
            specular_gain <= 16'd16384;
            shininess     <= 8'd32;
            mismatches    <= 0;
            intensity_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LIGHT_X:       light_x       <= cfg_data;
                    REG_LIGHT_Y:       light_y       <= cfg_data;
                    REG_LIGHT_Z:       light_z       <= cfg_data;
                    REG_AMBIENT_TERM:  ambient_term  <= cfg_data[15:0];
                    REG_DIFFUSE_GAIN:  diffuse_gain  <= cfg_data[15:0];
                    REG_SPECULAR_GAIN: specular_gain <= cfg_data[15:0];
                    REG_SHININESS:     shininess     <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                n[0] = s_normal_x; n[1] = s_normal_y; n[2] = s_normal_z;
                v[0] = s_view_x;   v[1] = s_view_y;   v[2] = s_view_z;
                intensity_q.push_back(shade_point(s_point_x, s_point_y, s_point_z, n, v));
            end
            if (m_valid && m_ready) begin
                if (intensity_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: intensity %0d", m_intensity);
                    mismatches <= mismatches + 1;
                end else begin
                    want = intensity_q.pop_front();
                    if (want !== m_intensity) begin
                        if (mismatches < 10)
                            $display("intensity mismatch: expected %0d, got %0d",
                                     want, m_intensity);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

[bench/phong_point_light_intensity_tb.sv]
// ----------------------------------------------------------------------------
// phong_point_light_intensity_tb
// Drives the point-light shader with directed and random surface points,
// normals and view vectors across several light settings, with bursty
// requests and a stalling result side; the checker predicts and compares.
// ----------------------------------------------------------------------------
module phong_point_light_intensity_tb;
    import pplight_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 160;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [31:0]   s_point_x, s_point_y, s_point_z;
    logic signed [15:0]   s_normal_x, s_normal_y, s_normal_z;
    logic signed [15:0]   s_view_x, s_view_y, s_view_z;
    logic                 m_valid;
    logic                 m_ready;
    logic [15:0]          m_intensity;
    int                   mismatches;
    int                   pending;
    int                   cycles;
    int                   hold_req;

    phong_point_light_intensity dut (.*);
    phong_point_light_intensity_checker checker_i (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("phong_point_light_intensity_tb failed");
            $finish;
        end
    end

    // result side: random ready modes, plus a long hold when requested
    always @(posedge aclk) begin
        int mode_left, mode, hold_left, hold_seen;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            mode_left = 0;
            mode      = 0;
            hold_left = 0;
            hold_seen = 0;
        end else begin
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = 600;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 400);
            end
            mode_left = mode_left - 1;
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_light(input logic [31:0] lx, input logic [31:0] ly,
                              input logic [31:0] lz, input logic [15:0] amb,
                              input logic [15:0] dg, input logic [15:0] sg,
                              input logic [7:0] sh);
        cfg_write(REG_LIGHT_X, lx);
        cfg_write(REG_LIGHT_Y, ly);
        cfg_write(REG_LIGHT_Z, lz);
        cfg_write(REG_AMBIENT_TERM, {16'h0, amb});
        cfg_write(REG_DIFFUSE_GAIN, {16'h0, dg});
        cfg_write(REG_SPECULAR_GAIN, {16'h0, sg});
        cfg_write(REG_SHININESS, {24'h0, sh});
    endtask

    // leaves valid high; the caller lowers it on a gap
    task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input logic [15:0] nx,
                              input logic [15:0] ny, input logic [15:0] nz,
                              input logic [15:0] vx, input logic [15:0] vy,
                              input logic [15:0] vz);
        s_valid    <= 1'b1;
        s_point_x  <= px;
        s_point_y  <= py;
        s_point_z  <= pz;
        s_normal_x <= nx;
        s_normal_y <= ny;
        s_normal_z <= nz;
        s_view_x   <= vx;
        s_view_y   <= vy;
        s_view_z   <= vz;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_for(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        idle_for(1);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] unitish();
        case ($urandom_range(0, 6))
            0:       return 16'sd16384;
            1:       return -16'sd16384;
            2:       return 16'sd11585;
            3:       return -16'sd11585;
            4:       return 16'sd9459;
            5:       return -16'sd9459;
            default: return 16'sd0;
        endcase
    endfunction

    function automatic logic [31:0] near_coord();
        return $urandom_range(0, 3) == 0 ? $urandom() : 32'($signed($urandom_range(0, 4194304)) - 2097152);
    endfunction

    task automatic random_points(input int count);
        int burst;
        logic [15:0] c [6];
        burst = $urandom_range(1, 30);
        for (int k = 0; k < count; k++) begin
            for (int j = 0; j < 6; j++)
                c[j] = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : unitish();
            send_point(near_coord(), near_coord(), near_coord(),
                       c[0], c[1], c[2], c[3], c[4], c[5]);
            if (k == count / 2) hold_req = hold_req + 1;
            burst = burst - 1;
            if (burst == 0) begin
                if ($urandom_range(0, 1) == 0) idle_for($urandom_range(1, 12));
                burst = $urandom_range(1, 30);
            end
        end
    endtask

    initial begin
        cycles     = 0;
        hold_req   = 0;
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_point_x  = '0; s_point_y  = '0; s_point_z  = '0;
        s_normal_x = '0; s_normal_y = '0; s_normal_z = '0;
        s_view_x   = '0; s_view_y   = '0; s_view_z   = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset light: straight on, light at the point, extremes
        send_point(0, 0, 0, 0, 0, 16384, 0, 0, 16384);
        send_point(32'sd655360, 32'sd655360, 32'sd1310720, 0, 0, 16384, 0, 0, 16384);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   16384, 0, 0, 0, 16384, 0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   0, 0, -16384, 0, 0, -16384);
        send_point(0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_point(0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
        send_point(0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_point(0, 0, 0, 0, 0, 0, 0, 0, 16384);
        send_point(0, 0, 0, 0, 0, 16384, 0, 0, 0);
        send_point(0, 0, 0, 0, 0, 16384, 0, 0, -16384);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 11585, 0, 11585, 0, 11585, 11585);
        send_point(32'hFFFF_FFFF, 1, 32'h0001_0000, 9459, 9459, 9459, -9459, 9459, 9459);
        drain();

        // extremes of every register but light z; the unused index must be ignored
        cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
        load_light(32'h8000_0000, 32'h7FFF_FFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
        send_point(0, 0, 0, 0, 0, 16384, 0, 0, 16384);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                   16384, 0, 0, -16384, 0, 0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 16384, 0, 0, 16384, 0);
        random_points(150);
        drain();

        // shininess zero: power stays at one
        load_light(0, 0, 32'h0010_0000, 16'd0, 16'd0, 16'hFFFF, 8'd0);
        send_point(0, 0, 0, 0, 0, 16384, 0, 0, 16384);
        random_points(150);
        drain();

        load_light(32'h0003_0000, 32'hFFFD_0000, 32'h0005_0000,
                   16'd0, 16'd32768, 16'd32768, 8'd1);
        random_points(150);
        drain();

        load_light($urandom(), $urandom(), $urandom(), 16'($urandom()),
                   16'($urandom()), 16'($urandom()), 8'($urandom_range(1, 255)));
        random_points(150);
        drain();

        load_light(32'sd655360, 32'sd655360, 32'sd1310720, 16'd13107,
                   16'd16384, 16'd16384, 8'd32);
        random_points(150);
        drain();

        if (mismatches == 0 && pending == 0) begin
            $display("phong_point_light_intensity_tb passed");
        end else begin
            $display("phong_point_light_intensity_tb failed");
        end
        $finish;
    end
endmodule

[phong_point_light_intensity.f]
rtl/pplight_pkg.sv
rtl/pplight_norm.sv
rtl/phong_point_light_intensity.sv
rtl/pplight_checker.sv
bench/phong_point_light_intensity_checker.sv
bench/phong_point_light_intensity_tb.sv
